// ===== hdl/fvg_pkg.sv =====
// Package for the FAT32 volume geometry block: widths, thresholds, register
// indexes and the command/status structs shared by controller and datapath.
// No dependencies.
package fvg_pkg;

  // Iteration limit default
  localparam int MAX_ROUNDS_DEF = 8;

  // Field widths
  localparam int LBA_W  = 32;
  localparam int ADDR_W = 33;
  localparam int FATO_W = 24;
  localparam int SPC_W  = 5;
  localparam int STAT_W = 2;
  localparam int RSV_W  = 16;
  localparam int CPY_W  = 2;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 1;

  // Internal widths: FAT size needs 26 bits, copies * FAT 28, overhead 29
  localparam int FAT_W  = 26;
  localparam int PROD_W = FAT_W + CPY_W;
  localparam int OVH_W  = PROD_W + 1;
  localparam int SH_W   = 3;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_RESERVED = 1'b0;
  localparam logic [IDX_W-1:0] REG_COPIES   = 1'b1;

  // Configuration reset values
  localparam logic [RSV_W-1:0] RESERVED_RST = 16'd32;
  localparam logic [CPY_W-1:0] COPIES_RST   = 2'd2;

  // Size thresholds for sectors per cluster
  localparam logic [LBA_W-1:0] SPC4_LIMIT  = 32'd262144;
  localparam logic [LBA_W-1:0] SPC8_LIMIT  = 32'd1048576;
  localparam logic [LBA_W-1:0] SPC16_LIMIT = 32'd8388608;
  localparam logic [LBA_W-1:0] SMALL_LIMIT = 32'd65536;
  localparam logic [LBA_W-1:0] MIN_CLUSTERS = 32'd65525;

  // FAT entry sizing: 4 bytes per entry, 512 bytes per sector, 2 reserved entries
  localparam int SECTOR_SHIFT = 7;
  localparam int FAT_ROUND_ADD = 2 * 4 / 4 + (512 / 4) - 1;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SMALL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FEW_CLUST = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic ovh;
    logic eval;
    logic fin_ovh;
    logic fin_data;
    logic emit;
  } fvg_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic too_short;
    logic converged;
  } fvg_stat_t;

endpackage

// ===== hdl/fvg_ctrl.sv =====
// Controller for the FAT32 volume geometry block: sequences the FAT-size
// iteration and the final layout steps, and owns both channel handshakes.
// Depends on fvg_pkg.
module fvg_ctrl #(
  parameter int MAX_ROUNDS = fvg_pkg::MAX_ROUNDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  fvg_pkg::fvg_stat_t st,
  output fvg_pkg::fvg_cmd_t  cmd
);

  localparam int RW = $clog2(MAX_ROUNDS + 1);
  localparam logic [RW-1:0] LAST_ROUND = RW'(MAX_ROUNDS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OVH   = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_FOVH  = 3'd3;
  localparam logic [2:0] S_FDATA = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [RW-1:0] round_r, round_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          round_nxt = '0;
          state_nxt = S_OVH;
        end
      end
      S_OVH: begin
        if (st.too_short) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.ovh   = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (st.converged || round_r == LAST_ROUND) begin
          state_nxt = S_FOVH;
        end else begin
          round_nxt = round_r + 1'b1;
          state_nxt = S_OVH;
        end
      end
      S_FOVH: begin
        cmd.fin_ovh = 1'b1;
        state_nxt   = S_FDATA;
      end
      S_FDATA: begin
        cmd.fin_data = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid: set on emit, drop when the transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/fvg_dpath.sv =====
// Datapath for the FAT32 volume geometry block: configuration registers,
// FAT-size iteration registers, address adders and the result register.
// Depends on fvg_pkg.
module fvg_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fvg_pkg::IDX_W-1:0]      cfg_index,
  input  logic [fvg_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic [fvg_pkg::LBA_W-1:0]      in_partition_start,
  input  logic [fvg_pkg::LBA_W-1:0]      in_partition_length,
  input  fvg_pkg::fvg_cmd_t              cmd,
  output fvg_pkg::fvg_stat_t             st,
  output logic [fvg_pkg::STAT_W-1:0]     out_status,
  output logic [fvg_pkg::SPC_W-1:0]      out_cluster_sectors,
  output logic [fvg_pkg::FATO_W-1:0]     out_fat_sectors,
  output logic [fvg_pkg::LBA_W-1:0]      out_data_region_sectors,
  output logic [fvg_pkg::LBA_W-1:0]      out_total_clusters,
  output logic [fvg_pkg::ADDR_W-1:0]     out_first_fat_address,
  output logic [fvg_pkg::ADDR_W-1:0]     out_second_fat_address,
  output logic [fvg_pkg::ADDR_W-1:0]     out_root_cluster_address
);

  localparam int LBA_W  = fvg_pkg::LBA_W;
  localparam int ADDR_W = fvg_pkg::ADDR_W;
  localparam int FAT_W  = fvg_pkg::FAT_W;
  localparam int PROD_W = fvg_pkg::PROD_W;
  localparam int OVH_W  = fvg_pkg::OVH_W;
  localparam int SH_W   = fvg_pkg::SH_W;
  localparam int SPC_W  = fvg_pkg::SPC_W;

  logic [fvg_pkg::RSV_W-1:0] reserved_r;
  logic [fvg_pkg::CPY_W-1:0] copies_r;

  logic [LBA_W-1:0]  start_r, len_r;
  logic              small_r;
  logic [SH_W-1:0]   shift_r;
  logic [SPC_W-1:0]  spc_r;
  logic [FAT_W-1:0]  fat_r;
  logic [PROD_W-1:0] prod_r;
  logic [OVH_W-1:0]  ovh_r;
  logic [LBA_W-1:0]  data_r;
  logic [ADDR_W-1:0] first_r, second_r, root_r;

  logic [SH_W-1:0]   shift_nxt;
  logic [SPC_W-1:0]  spc_nxt;
  logic [PROD_W-1:0] prod;
  logic [OVH_W-1:0]  ovh;
  logic [LBA_W-1:0]  data;
  logic [LBA_W-1:0]  clusters;
  logic [LBA_W:0]    fat_sum;
  logic [FAT_W-1:0]  fat_next;
  logic [LBA_W-1:0]  clust_out;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= fvg_pkg::RESERVED_RST;
      copies_r   <= fvg_pkg::COPIES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fvg_pkg::REG_RESERVED: reserved_r <= cfg_wdata;
        fvg_pkg::REG_COPIES:   copies_r   <= cfg_wdata[fvg_pkg::CPY_W-1:0];
        default: ;
      endcase
    end
  end

  // Cluster size from partition length
  always_comb begin
    if (in_partition_length < fvg_pkg::SPC4_LIMIT) begin
      shift_nxt = 3'd0;
      spc_nxt   = 5'd1;
    end else if (in_partition_length < fvg_pkg::SPC8_LIMIT) begin
      shift_nxt = 3'd2;
      spc_nxt   = 5'd4;
    end else if (in_partition_length < fvg_pkg::SPC16_LIMIT) begin
      shift_nxt = 3'd3;
      spc_nxt   = 5'd8;
    end else begin
      shift_nxt = 3'd4;
      spc_nxt   = 5'd16;
    end
  end

  // Overhead: reserved plus all FAT copies
  assign prod = PROD_W'(copies_r) * PROD_W'(fat_r);
  assign ovh  = OVH_W'(reserved_r) + OVH_W'(prod);

  // Data sectors saturate at zero, then one FAT sizing step
  assign data     = (LBA_W'(ovh_r) >= len_r) ? '0 : (len_r - LBA_W'(ovh_r));
  assign clusters = data >> shift_r;
  assign fat_sum  = (LBA_W+1)'(clusters) + (LBA_W+1)'(fvg_pkg::FAT_ROUND_ADD);
  assign fat_next = FAT_W'(fat_sum >> fvg_pkg::SECTOR_SHIFT);

  assign st.too_short = small_r;
  assign st.converged = (fat_next == fat_r);

  // Iteration and layout registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_r <= in_partition_start;
      len_r   <= in_partition_length;
      small_r <= (in_partition_length <= fvg_pkg::SMALL_LIMIT);
      shift_r <= shift_nxt;
      spc_r   <= spc_nxt;
      fat_r   <= FAT_W'(1);
    end
    if (cmd.ovh || cmd.fin_ovh) begin
      ovh_r  <= ovh;
      prod_r <= prod;
    end
    if (cmd.fin_ovh) begin
      first_r <= ADDR_W'(start_r) + ADDR_W'(reserved_r);
    end
    if (cmd.eval && !st.converged) begin
      fat_r <= fat_next;
    end
    if (cmd.fin_data) begin
      data_r   <= data;
      second_r <= first_r + ADDR_W'(fat_r);
      root_r   <= first_r + ADDR_W'(prod_r);
    end
  end

  assign clust_out = data_r >> shift_r;

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (small_r) begin
        out_status               <= fvg_pkg::STAT_SMALL;
        out_cluster_sectors      <= '0;
        out_fat_sectors          <= '0;
        out_data_region_sectors  <= '0;
        out_total_clusters       <= '0;
        out_first_fat_address    <= '0;
        out_second_fat_address   <= '0;
        out_root_cluster_address <= '0;
      end else begin
        out_status <= (clust_out < fvg_pkg::MIN_CLUSTERS) ? fvg_pkg::STAT_FEW_CLUST
                                                          : fvg_pkg::STAT_OK;
        out_cluster_sectors      <= spc_r;
        out_fat_sectors          <= fat_r[fvg_pkg::FATO_W-1:0];
        out_data_region_sectors  <= data_r;
        out_total_clusters       <= clust_out;
        out_first_fat_address    <= first_r;
        out_second_fat_address   <= second_r;
        out_root_cluster_address <= root_r;
      end
    end
  end

endmodule

// ===== hdl/fat32_volume_geometry_core.sv =====
// Top level of the FAT32 volume geometry block: joins controller and datapath.
// Depends on fvg_pkg, fvg_ctrl and fvg_dpath.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_stall    partition_start, partition_length
//   out      out  out_valid/out_stall  status ... root_cluster_address
//   cfg      in   cfg_we               cfg_index, cfg_wdata
//
// A partition runs R FAT-size rounds and then the final overhead and data steps,
// where R (1 to MAX_ROUNDS) is the number of FAT-size rounds; each round is one
// overhead step and one evaluation step through the shared sizing adders.
// A partition of 65536 sectors or fewer skips these steps and goes to the result.
// Reset is synchronous and active low and restores reserved = 32, copies = 2.
// in_stall is high while an item is in work; a stalled result holds in the
// output register and the next item waits in the controller until it leaves.
module fat32_volume_geometry_core #(
  parameter int MAX_ROUNDS = fvg_pkg::MAX_ROUNDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fvg_pkg::IDX_W-1:0]      cfg_index,
  input  logic [fvg_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [fvg_pkg::LBA_W-1:0]      in_partition_start,
  input  logic [fvg_pkg::LBA_W-1:0]      in_partition_length,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fvg_pkg::STAT_W-1:0]     out_status,
  output logic [fvg_pkg::SPC_W-1:0]      out_cluster_sectors,
  output logic [fvg_pkg::FATO_W-1:0]     out_fat_sectors,
  output logic [fvg_pkg::LBA_W-1:0]      out_data_region_sectors,
  output logic [fvg_pkg::LBA_W-1:0]      out_total_clusters,
  output logic [fvg_pkg::ADDR_W-1:0]     out_first_fat_address,
  output logic [fvg_pkg::ADDR_W-1:0]     out_second_fat_address,
  output logic [fvg_pkg::ADDR_W-1:0]     out_root_cluster_address
);

  fvg_pkg::fvg_cmd_t  cmd;
  fvg_pkg::fvg_stat_t st;

  // Sequencer
  fvg_ctrl #(
    .MAX_ROUNDS(MAX_ROUNDS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Arithmetic and result register
  fvg_dpath u_dpath (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .in_partition_start      (in_partition_start),
    .in_partition_length     (in_partition_length),
    .cmd                     (cmd),
    .st                      (st),
    .out_status              (out_status),
    .out_cluster_sectors     (out_cluster_sectors),
    .out_fat_sectors         (out_fat_sectors),
    .out_data_region_sectors (out_data_region_sectors),
    .out_total_clusters      (out_total_clusters),
    .out_first_fat_address   (out_first_fat_address),
    .out_second_fat_address  (out_second_fat_address),
    .out_root_cluster_address(out_root_cluster_address)
  );

endmodule
